[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL in this folder.
// Each macro takes a label, the clock, the active-low reset, a property or expression and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

[rtl/core/tcf_pkg.sv]
package tcf_pkg;

  // Width of one byte on the line.
  localparam int unsigned BYTE_W = 8;

  // Telnet command codes.
  localparam logic [BYTE_W-1:0] TN_IAC  = 8'hFF;
  localparam logic [BYTE_W-1:0] TN_SE   = 8'hF0;
  localparam logic [BYTE_W-1:0] TN_SB   = 8'hFA;
  localparam logic [BYTE_W-1:0] TN_WILL = 8'hFB;
  localparam logic [BYTE_W-1:0] TN_DO   = 8'hFD;
  localparam logic [BYTE_W-1:0] TN_WONT = 8'hFC;

  // Kind of a result word.
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // Position of a word within a three-word reply.
  localparam logic [1:0] REPLY_POS_IAC  = 2'd0;
  localparam logic [1:0] REPLY_POS_WONT = 2'd1;
  localparam logic [1:0] REPLY_POS_OPT  = 2'd2;

  // Receive parser modes.
  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_IAC     = 3'd1,
    MODE_WILL    = 3'd2,
    MODE_DO      = 3'd3,
    MODE_SUB     = 3'd4,
    MODE_SUB_IAC = 3'd5
  } tcf_mode_e;

endpackage

[rtl/core/tcf_intf.sv]
// Receive channel: one Telnet byte per word.
interface tcf_in_if import tcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Result channel: data bytes for the application and reply bytes for the peer.
interface tcf_out_if import tcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  modport source (output valid, output out_kind, output out_byte, output out_last,
                  input ready);
  modport sink (input valid, input out_kind, input out_byte, input out_last,
                output ready);
endinterface

[rtl/core/telnet_command_filter_core.sv]
// Channel | Dir | Payload                     | Words per input byte
// in_i    | in  | rx_byte                     | 1
// out_o   | out | out_kind, out_byte, out_last| 0, 1 or 3
//
// A byte is decoded in the cycle it is accepted; its results sit in one result register.
// Bytes giving zero or one result are taken every cycle, even while the previous result
// waits, as long as that result leaves in the same cycle.
// A DO option byte makes a three-word reply; the input stalls while the reply is sent and the
// next byte is taken in the cycle the last reply word leaves.
// Reset puts the parser in normal data mode and empties the result register.
// A stall on out_o stalls in_i only once the result register holds a word not yet taken.
module telnet_command_filter_core import tcf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcf_in_if.sink    in_i,
  tcf_out_if.source out_o
);

`include "assert_macros.svh"

  tcf_mode_e         mode_q, mode_d;
  logic              pend_valid_q, pend_valid_d;
  logic              pend_reply_q, pend_reply_d;
  logic [BYTE_W-1:0] pend_byte_q, pend_byte_d;
  logic [1:0]        pend_pos_q, pend_pos_d;

  logic              res_valid;
  logic              res_reply;
  logic              out_last;
  logic              out_fire;
  logic              in_fire;

  // Output word selection from the result register.
  always_comb begin
    out_last = 1'b1;
    out_o.out_byte = pend_byte_q;
    if (pend_reply_q) begin
      case (pend_pos_q)
        REPLY_POS_IAC:  out_o.out_byte = TN_IAC;
        REPLY_POS_WONT: out_o.out_byte = TN_WONT;
        default:        out_o.out_byte = pend_byte_q;
      endcase
      out_last = (pend_pos_q == REPLY_POS_OPT);
    end
  end

  assign out_o.valid    = pend_valid_q;
  assign out_o.out_kind = pend_reply_q ? KIND_REPLY : KIND_DATA;
  assign out_o.out_last = out_last;
  assign out_fire       = pend_valid_q && out_o.ready;

  // Take a new byte when the result register is free or drains its last word now.
  assign in_i.ready = !pend_valid_q || (out_o.ready && out_last);
  assign in_fire    = in_i.valid && in_i.ready;

  // Parser decode: next mode and the kind of result this byte causes.
  always_comb begin
    mode_d    = MODE_NORMAL;
    res_valid = 1'b0;
    res_reply = 1'b0;
    unique case (mode_q)
      MODE_IAC: begin
        if (in_i.rx_byte == TN_IAC) begin
          res_valid = 1'b1;
        end else if (in_i.rx_byte == TN_WILL) begin
          mode_d = MODE_WILL;
        end else if (in_i.rx_byte == TN_DO) begin
          mode_d = MODE_DO;
        end else if (in_i.rx_byte == TN_SB) begin
          mode_d = MODE_SUB;
        end
      end
      MODE_WILL: begin
        mode_d = MODE_NORMAL;
      end
      MODE_DO: begin
        res_valid = 1'b1;
        res_reply = 1'b1;
      end
      MODE_SUB: begin
        mode_d = (in_i.rx_byte == TN_IAC) ? MODE_SUB_IAC : MODE_SUB;
      end
      MODE_SUB_IAC: begin
        mode_d = (in_i.rx_byte == TN_SE) ? MODE_NORMAL : MODE_SUB;
      end
      default: begin
        if (in_i.rx_byte == TN_IAC) begin
          mode_d = MODE_IAC;
        end else begin
          res_valid = 1'b1;
        end
      end
    endcase
  end

  // Result register next value: load a new result, step through the reply, or empty it when the last word leaves.
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_reply_d = pend_reply_q;
    pend_byte_d  = pend_byte_q;
    pend_pos_d   = pend_pos_q;
    if (in_fire && res_valid) begin
      pend_valid_d = 1'b1;
      pend_reply_d = res_reply;
      pend_byte_d  = in_i.rx_byte;
      pend_pos_d   = REPLY_POS_IAC;
    end else if (out_fire) begin
      if (out_last) begin
        pend_valid_d = 1'b0;
      end else begin
        pend_pos_d = pend_pos_q + 2'd1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_NORMAL;
      pend_valid_q <= 1'b0;
      pend_reply_q <= 1'b0;
      pend_pos_q   <= REPLY_POS_IAC;
    end else begin
      if (in_fire) begin
        mode_q <= mode_d;
      end
      pend_valid_q <= pend_valid_d;
      pend_reply_q <= pend_reply_d;
      pend_pos_q   <= pend_pos_d;
    end
  end

  // Payload byte.
  always_ff @(posedge clk_i) begin
    pend_byte_q <= pend_byte_d;
  end

  // Checks on the parser and the result register.
  `ASSERT_NEVER(a_pos_range, clk_i, rst_ni, pend_valid_q && pend_pos_q == 2'd3, "reply position out of range")
  `ASSERT_NEVER(a_data_pos, clk_i, rst_ni, pend_valid_q && !pend_reply_q && pend_pos_q != REPLY_POS_IAC, "data word with nonzero position")
  `ASSERT_AT(a_do_reply, clk_i, rst_ni, in_fire && mode_q == MODE_DO |=> pend_valid_q && pend_reply_q && pend_pos_q == REPLY_POS_IAC, "DO option did not start a reply")
  `ASSERT_AT(a_sub_silent, clk_i, rst_ni, in_fire && mode_q == MODE_SUB |=> !pend_valid_q, "suboption byte produced a result")

endmodule
